>>> hdl/bsmp_pkg.sv
package bsmp_pkg;

  // Table geometry
  localparam int SLOTS     = 64;
  localparam int CONN_BITS = 16;
  localparam int SLOT_W    = $clog2(SLOTS);
  localparam int TOTAL_W   = $clog2(SLOTS + 1);

  // Fixed field widths of the channels
  localparam int ACTION_W = 2;
  localparam int TARGET_W = 6;
  localparam int WEIGHT_W = 16;
  localparam int RAND_W   = 16;
  localparam int STATUS_W = 2;
  localparam int REPORT_W = 16;

  localparam logic [CONN_BITS-1:0] CONN_MAX = '1;

  // Actions
  localparam logic [ACTION_W-1:0] ACT_SELECT  = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_RELEASE = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_ADD     = 2'd2;
  localparam logic [ACTION_W-1:0] ACT_REMOVE  = 2'd3;

  // Selection policies
  localparam logic [1:0] POL_RR     = 2'd0;
  localparam logic [1:0] POL_LEAST  = 2'd1;
  localparam logic [1:0] POL_RANDOM = 2'd2;
  localparam logic [1:0] POL_WEIGHT = 2'd3;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_BACKEND = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL       = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND  = 2'd3;

  // Controller to datapath commands
  typedef struct packed {
    logic start;   // latch the item, clear the search state
    logic div_go;  // start the modulo unit
    logic scan;    // issue one slot of the table walk
    logic upd;     // apply the action and load the result
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [1:0]          policy;
    logic                empty;
    logic                div_busy;
    logic                scan_last;
  } sts_t;

endpackage

>>> hdl/bsmp_if.sv
interface bsmp_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [5:0]  target_slot;
  logic [15:0] new_weight;
  logic [15:0] random_value;

  modport source (output valid, action, target_slot, new_weight, random_value, input ready);
  modport sink   (input valid, action, target_slot, new_weight, random_value, output ready);
endinterface

interface bsmp_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [5:0]  chosen_slot;
  logic [15:0] slot_connections;

  modport source (output valid, status, chosen_slot, slot_connections, input ready);
  modport sink   (input valid, status, chosen_slot, slot_connections, output ready);
endinterface

interface bsmp_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

>>> hdl/bsmp_div.sv
module bsmp_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          go,
  input  logic [bsmp_pkg::RAND_W-1:0]   dividend,
  input  logic [bsmp_pkg::TOTAL_W-1:0]  divisor,
  output logic                          busy,
  output logic [bsmp_pkg::TOTAL_W-1:0]  rem
);
  import bsmp_pkg::*;

  localparam int STEPS  = RAND_W;
  localparam int STEP_W = $clog2(STEPS + 1);

  logic [RAND_W-1:0]  dvd;
  logic [STEP_W-1:0]  steps_left;
  logic [TOTAL_W:0]   trial;
  logic [TOTAL_W:0]   diff;

  // Bring down one dividend bit and try the subtract
  assign trial = {rem, dvd[RAND_W-1]};
  assign diff  = trial - {1'b0, divisor};

  // Restoring remainder, one bit a cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      steps_left <= '0;
    end else if (go) begin
      busy       <= 1'b1;
      steps_left <= STEP_W'(STEPS);
    end else if (busy) begin
      steps_left <= steps_left - STEP_W'(1);
      if (steps_left == STEP_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      dvd <= dividend;
      rem <= '0;
    end else if (busy) begin
      dvd <= dvd << 1;
      if (trial >= {1'b0, divisor}) begin
        rem <= diff[TOTAL_W-1:0];
      end else begin
        rem <= trial[TOTAL_W-1:0];
      end
    end
  end

endmodule

>>> hdl/bsmp_dp.sv
module bsmp_dp (
  input  logic                            clk,
  input  logic                            rst,
  input  bsmp_pkg::cmd_t                  cmd,
  output bsmp_pkg::sts_t                  sts,
  input  logic [bsmp_pkg::ACTION_W-1:0]   req_action,
  input  logic [bsmp_pkg::TARGET_W-1:0]   req_target_slot,
  input  logic [bsmp_pkg::WEIGHT_W-1:0]   req_new_weight,
  input  logic [bsmp_pkg::RAND_W-1:0]     req_random_value,
  input  logic                            cfg_write,
  input  logic [1:0]                      cfg_data,
  output logic [bsmp_pkg::STATUS_W-1:0]   rsp_status,
  output logic [bsmp_pkg::TARGET_W-1:0]   rsp_chosen_slot,
  output logic [bsmp_pkg::REPORT_W-1:0]   rsp_slot_connections
);
  import bsmp_pkg::*;

  // Table: valid marks in flops, weights and counts in memories
  logic [SLOTS-1:0]            slot_valid;
  logic [CONN_BITS-1:0]        cnt_mem [SLOTS];
  logic [WEIGHT_W-1:0]         wt_mem  [SLOTS];
  logic [CONN_BITS-1:0]        rd_cnt;
  logic signed [WEIGHT_W-1:0]  rd_wt;
  logic [SLOT_W-1:0]           rd_addr;

  logic [1:0]                  policy;
  logic [SLOT_W-1:0]           rr_pointer;
  logic [TOTAL_W-1:0]          backend_total;

  // Latched item
  logic [ACTION_W-1:0]         item_action;
  logic [TARGET_W-1:0]         item_target;
  logic [WEIGHT_W-1:0]         item_weight;
  logic [RAND_W-1:0]           item_random;

  // Walk state
  logic [SLOT_W:0]             scan_cnt;
  logic [SLOT_W-1:0]           p_idx;
  logic                        p_live;
  logic                        found;
  logic [SLOT_W-1:0]           pick;
  logic [CONN_BITS-1:0]        best;
  logic [TOTAL_W-1:0]          seen;

  // Modulo unit
  logic                        div_busy;
  logic [TOTAL_W-1:0]          rem;
  logic [RAND_W-1:0]           dividend;
  logic [TOTAL_W-1:0]          rem_inc;

  logic [SLOT_W-1:0]           tgt_idx;
  logic                        tgt_ok;
  logic [SLOT_W-1:0]           op_idx;
  logic                        fail;
  logic [STATUS_W-1:0]         fail_code;
  logic [CONN_BITS-1:0]        cnt_next;
  logic                        p_valid;

  bsmp_div u_div (
    .clk      (clk),
    .rst      (rst),
    .go       (cmd.div_go),
    .dividend (dividend),
    .divisor  (backend_total),
    .busy     (div_busy),
    .rem      (rem)
  );

  assign dividend = (policy == POL_RR) ? RAND_W'(rr_pointer) : item_random;
  assign rem_inc  = rem + TOTAL_W'(1);

  assign sts.action    = item_action;
  assign sts.policy    = policy;
  assign sts.empty     = (backend_total == '0);
  assign sts.div_busy  = div_busy;
  assign sts.scan_last = (scan_cnt == (SLOT_W + 1)'(SLOTS - 1));

  // Target check and the slot the action works on
  assign tgt_idx = SLOT_W'(item_target);
  assign tgt_ok  = (32'(item_target) < SLOTS) && slot_valid[tgt_idx];
  assign op_idx  = (item_action == ACT_SELECT || item_action == ACT_ADD) ? pick : tgt_idx;
  assign rd_addr = cmd.scan ? scan_cnt[SLOT_W-1:0] : op_idx;
  assign p_valid = slot_valid[p_idx];

  always_comb begin
    case (item_action)
      ACT_SELECT: begin
        fail      = !found;
        fail_code = ST_NO_BACKEND;
      end
      ACT_ADD: begin
        fail      = !found;
        fail_code = ST_FULL;
      end
      default: begin
        fail      = !tgt_ok;
        fail_code = ST_NOT_FOUND;
      end
    endcase
  end

  // Saturating count update
  always_comb begin
    case (item_action)
      ACT_SELECT:  cnt_next = (rd_cnt == CONN_MAX) ? rd_cnt : rd_cnt + CONN_BITS'(1);
      ACT_RELEASE: cnt_next = (rd_cnt == '0) ? rd_cnt : rd_cnt - CONN_BITS'(1);
      default:     cnt_next = '0;
    endcase
  end

  // Memory ports: one registered read, one write
  always_ff @(posedge clk) begin
    rd_cnt <= cnt_mem[rd_addr];
    rd_wt  <= wt_mem[rd_addr];
    if (cmd.upd && !fail) begin
      cnt_mem[op_idx] <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.upd && !fail && item_action == ACT_ADD) begin
      wt_mem[op_idx] <= item_weight;
    end
  end

  // Latch the item on its beat
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      item_action <= req_action;
      item_target <= req_target_slot;
      item_weight <= req_new_weight;
      item_random <= req_random_value;
    end
  end

  // Policy register
  always_ff @(posedge clk) begin
    if (rst) begin
      policy <= POL_RR;
    end else if (cfg_write) begin
      policy <= cfg_data;
    end
  end

  // Walk counter and the delayed slot that matches the read data
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_cnt <= '0;
      p_live   <= 1'b0;
    end else begin
      p_live <= cmd.scan;
      if (cmd.start) begin
        scan_cnt <= '0;
      end else if (cmd.scan) begin
        scan_cnt <= scan_cnt + (SLOT_W + 1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    p_idx <= scan_cnt[SLOT_W-1:0];
  end

  // Judge one slot a cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      found <= 1'b0;
    end else if (cmd.start) begin
      found <= 1'b0;
      seen  <= '0;
    end else if (p_live) begin
      if (item_action == ACT_ADD) begin
        if (!found && !p_valid) begin
          found <= 1'b1;
          pick  <= p_idx;
        end
      end else begin
        case (policy)
          POL_LEAST: begin
            if (p_valid && (!found || rd_cnt < best)) begin
              found <= 1'b1;
              pick  <= p_idx;
              best  <= rd_cnt;
            end
          end
          POL_WEIGHT: begin
            if (!found && p_valid && rd_wt > $signed(WEIGHT_W'(0))) begin
              found <= 1'b1;
              pick  <= p_idx;
            end
          end
          default: begin
            if (!found && p_valid) begin
              if (seen == rem) begin
                found <= 1'b1;
                pick  <= p_idx;
              end else begin
                seen <= seen + TOTAL_W'(1);
              end
            end
          end
        endcase
      end
    end
  end

  // Table bookkeeping on update
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid    <= '0;
      backend_total <= '0;
      rr_pointer    <= '0;
    end else if (cmd.upd && !fail) begin
      case (item_action)
        ACT_SELECT: begin
          if (policy == POL_RR) begin
            rr_pointer <= (rem_inc == backend_total) ? '0 : SLOT_W'(rem_inc);
          end
        end
        ACT_ADD: begin
          slot_valid[op_idx] <= 1'b1;
          backend_total      <= backend_total + TOTAL_W'(1);
        end
        ACT_REMOVE: begin
          slot_valid[op_idx] <= 1'b0;
          if (backend_total != '0) begin
            backend_total <= backend_total - TOTAL_W'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.upd) begin
      if (fail) begin
        rsp_status           <= fail_code;
        rsp_chosen_slot      <= '0;
        rsp_slot_connections <= '0;
      end else begin
        rsp_status           <= ST_OK;
        rsp_chosen_slot      <= TARGET_W'(op_idx);
        rsp_slot_connections <= REPORT_W'(cnt_next);
      end
    end
  end

endmodule

>>> hdl/bsmp_ctrl.sv
module bsmp_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  input  bsmp_pkg::sts_t sts,
  output bsmp_pkg::cmd_t cmd
);
  import bsmp_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DISP = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_SCAN = 3'd3;
  localparam logic [2:0] S_SEL  = 3'd4;
  localparam logic [2:0] S_PICK = 3'd5;
  localparam logic [2:0] S_UPD  = 3'd6;
  localparam logic [2:0] S_OUT  = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;

  assign req_ready = (state == S_IDLE);
  assign rsp_valid = (state == S_OUT);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.start  = 1'b1;
          state_next = S_DISP;
        end
      end
      // Route by action and policy
      S_DISP: begin
        case (sts.action)
          ACT_SELECT: begin
            if (sts.empty) begin
              state_next = S_PICK;
            end else if (sts.policy == POL_RR || sts.policy == POL_RANDOM) begin
              cmd.div_go = 1'b1;
              state_next = S_DIV;
            end else begin
              state_next = S_SCAN;
            end
          end
          ACT_ADD: state_next = S_SCAN;
          default: state_next = S_PICK;
        endcase
      end
      S_DIV: begin
        if (!sts.div_busy) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_last) begin
          state_next = S_SEL;
        end
      end
      // Last slot is judged here
      S_SEL:  state_next = S_PICK;
      // Read of the chosen slot's count is in flight
      S_PICK: state_next = S_UPD;
      S_UPD: begin
        cmd.upd    = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (rsp_ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

>>> hdl/backend_selector_multi_policy_core.sv
// Backend selector over a 64-slot table of weight and live connection count.
// One request is handled at a time; its result beat is offered on rsp and
// the next request is taken once that beat is accepted. Release and remove
// skip the walk and read and update the target slot. Add and the least
// connections and weighted selects walk every slot through the one read port
// of the weight and count memories. Round robin and random selects first
// form the slot index modulo the backend count in a one-bit-per-cycle
// remainder unit, then walk. A select on an empty table skips the walk.
// The policy register may be written at any time the block is idle; its
// port is always ready.
module backend_selector_multi_policy_core (
  input logic     clk,
  input logic     rst,
  bsmp_req_if.sink   req,
  bsmp_rsp_if.source rsp,
  bsmp_cfg_if.sink   cfg
);
  import bsmp_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg.ready = 1'b1;

  bsmp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  bsmp_dp u_dp (
    .clk                  (clk),
    .rst                  (rst),
    .cmd                  (cmd),
    .sts                  (sts),
    .req_action           (req.action),
    .req_target_slot      (req.target_slot),
    .req_new_weight       (req.new_weight),
    .req_random_value     (req.random_value),
    .cfg_write            (cfg.valid),
    .cfg_data             (cfg.data),
    .rsp_status           (rsp.status),
    .rsp_chosen_slot      (rsp.chosen_slot),
    .rsp_slot_connections (rsp.slot_connections)
  );

endmodule

>>> tb/sv/backend_selector_multi_policy_core_tb.sv
module backend_selector_multi_policy_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bsmp_pkg::*;

  localparam int HOLD_CYCLES      = 400;
  localparam int QUIET_LIMIT      = 20000;
  localparam int TAIL_CYCLES      = 100;
  localparam int ITEMS_PER_PHASE  = 115;

  typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [TARGET_W-1:0] target;
    logic [WEIGHT_W-1:0] weight;
    logic [RAND_W-1:0]   rnd;
  } req_beat_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot;
    logic [REPORT_W-1:0] conn;
  } rsp_beat_t;

  logic clk;
  logic rst;

  bsmp_req_if req_ch();
  bsmp_rsp_if rsp_ch();
  bsmp_cfg_if cfg_ch();

  backend_selector_multi_policy_core uut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  // Shadow copy of the slot table
  logic                       slot_live [SLOTS];
  logic signed [WEIGHT_W-1:0] slot_wt   [SLOTS];
  logic [CONN_BITS-1:0]       slot_conn [SLOTS];
  int                         rr_next;
  int                         live_total;
  logic [1:0]                 cur_policy;

  rsp_beat_t  pending_results[$];
  idle_mode_e idle_mode;
  bit         hold_start;
  int         err_cnt;
  int         sent_cnt;
  int         checked_cnt;
  int         status_cnt [4];

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  task automatic report_error(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    err_cnt++;
  endtask

  // Slot index of the k-th live entry in ascending order, SLOTS if none
  function automatic int live_nth(input int k);
    int seen;
    seen = 0;
    for (int s = 0; s < SLOTS; s++) begin
      if (slot_live[s]) begin
        if (seen == k) return s;
        seen++;
      end
    end
    return SLOTS;
  endfunction

  // Apply one request to the shadow table and work out its result beat
  function automatic rsp_beat_t predict_result(input req_beat_t r);
    rsp_beat_t res;
    int        pick;
    int        k;
    logic [CONN_BITS-1:0] best;
    res  = '0;
    pick = SLOTS;
    best = '0;
    case (r.action)
      ACT_SELECT: begin
        if (live_total == 0) begin
          res.status = ST_NO_BACKEND;
        end else begin
          case (cur_policy)
            POL_RR: begin
              k       = rr_next % live_total;
              pick    = live_nth(k);
              rr_next = (k + 1) % live_total;
            end
            POL_LEAST: begin
              for (int s = 0; s < SLOTS; s++) begin
                if (slot_live[s] && (pick == SLOTS || slot_conn[s] < best)) begin
                  pick = s;
                  best = slot_conn[s];
                end
              end
            end
            POL_RANDOM: begin
              pick = live_nth(int'(r.rnd) % live_total);
            end
            default: begin
              for (int s = 0; s < SLOTS; s++) begin
                if (slot_live[s] && slot_wt[s] > 0) begin
                  pick = s;
                  break;
                end
              end
            end
          endcase
          if (pick == SLOTS) begin
            res.status = ST_NO_BACKEND;
          end else begin
            if (slot_conn[pick] != CONN_MAX)
              slot_conn[pick] = slot_conn[pick] + CONN_BITS'(1);
            res.status = ST_OK;
            res.slot   = pick[SLOT_W-1:0];
            res.conn   = slot_conn[pick][REPORT_W-1:0];
          end
        end
      end
      ACT_ADD: begin
        for (int s = 0; s < SLOTS; s++) begin
          if (!slot_live[s]) begin
            pick = s;
            break;
          end
        end
        if (pick == SLOTS) begin
          res.status = ST_FULL;
        end else begin
          slot_live[pick] = 1'b1;
          slot_wt[pick]   = $signed(r.weight);
          slot_conn[pick] = '0;
          live_total++;
          res.status = ST_OK;
          res.slot   = pick[SLOT_W-1:0];
        end
      end
      default: begin
        if (!slot_live[r.target]) begin
          res.status = ST_NOT_FOUND;
        end else if (r.action == ACT_RELEASE) begin
          if (slot_conn[r.target] != '0)
            slot_conn[r.target] = slot_conn[r.target] - CONN_BITS'(1);
          res.status = ST_OK;
          res.slot   = r.target;
          res.conn   = slot_conn[r.target][REPORT_W-1:0];
        end else begin
          slot_live[r.target] = 1'b0;
          slot_conn[r.target] = '0;
          if (live_total > 0) live_total--;
          res.status = ST_OK;
          res.slot   = r.target;
        end
      end
    endcase
    return res;
  endfunction

  // Track register writes and request beats, queue the expected result
  always @(posedge clk) begin : track_requests
    req_beat_t r;
    if (rst) begin
      for (int s = 0; s < SLOTS; s++) begin
        slot_live[s] = 1'b0;
        slot_wt[s]   = '0;
        slot_conn[s] = '0;
      end
      rr_next    = 0;
      live_total = 0;
      cur_policy = POL_RR;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) cur_policy = cfg_ch.data;
      if (req_ch.valid && req_ch.ready) begin
        r = {req_ch.action, req_ch.target_slot, req_ch.new_weight, req_ch.random_value};
        pending_results.push_back(predict_result(r));
      end
    end
  end

  // Compare each result beat with the oldest expectation
  always @(posedge clk) begin : check_results
    rsp_beat_t got;
    rsp_beat_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      got = {rsp_ch.status, rsp_ch.chosen_slot, rsp_ch.slot_connections};
      if (pending_results.size() == 0) begin
        report_error($sformatf("result beat %0d arrived with nothing outstanding",
                               checked_cnt));
      end else begin
        want = pending_results.pop_front();
        if (got.status !== want.status)
          report_error($sformatf("beat %0d status %0d, want %0d",
                                 checked_cnt, got.status, want.status));
        if (got.slot !== want.slot)
          report_error($sformatf("beat %0d chosen_slot %0d, want %0d",
                                 checked_cnt, got.slot, want.slot));
        if (got.conn !== want.conn)
          report_error($sformatf("beat %0d slot_connections %0d, want %0d",
                                 checked_cnt, got.conn, want.conn));
      end
      status_cnt[got.status]++;
      checked_cnt++;
    end
  end

  // Drive result ready: random stalls by phase, plus a long hold-off on request
  initial begin : drive_rsp_ready
    int hold_left;
    int stall_pct;
    hold_left    = 0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_start) begin
        hold_start = 1'b0;
        hold_left  = HOLD_CYCLES;
      end
      stall_pct = (idle_mode == IDLE_RECEIVER) ? 49 : (idle_mode == IDLE_BOTH) ? 24 : 0;
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // End the run after a long stretch with no beat on any channel
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("Timeout: no beat accepted for %0d cycles", QUIET_LIMIT);
    $display("Mismatches found");
    $finish;
  end

  // Offer one request beat, after a random gap when the phase asks for one
  task automatic send_request(input logic [ACTION_W-1:0] act,
                              input logic [TARGET_W-1:0] tgt,
                              input logic [WEIGHT_W-1:0] wt,
                              input logic [RAND_W-1:0]   rv);
    int gap_pct;
    gap_pct = (idle_mode == IDLE_SENDER) ? 49 : (idle_mode == IDLE_BOTH) ? 24 : 0;
    while ($urandom_range(99) < gap_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid        <= 1'b1;
    req_ch.action       <= act;
    req_ch.target_slot  <= tgt;
    req_ch.new_weight   <= wt;
    req_ch.random_value <= rv;
    do @(posedge clk); while (!req_ch.ready);
    sent_cnt++;
  endtask

  // Drop valid and wait until every expected result has come back
  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  task automatic write_policy(input logic [1:0] pol);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= pol;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
  endtask

  // Mostly a live slot, sometimes any slot at all
  function automatic logic [TARGET_W-1:0] pick_target();
    int s;
    if (live_total > 0 && $urandom_range(9) < 7) begin
      s = live_nth($urandom_range(live_total - 1));
      if (s < SLOTS) return s[TARGET_W-1:0];
    end
    return TARGET_W'($urandom_range(SLOTS - 1));
  endfunction

  function automatic logic [WEIGHT_W-1:0] pick_weight();
    case ($urandom_range(7))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      2:       return 16'h0000;
      3:       return 16'h0001;
      default: return WEIGHT_W'($urandom());
    endcase
  endfunction

  // Random request; thin out adds once the table is well populated
  task automatic send_random_item();
    int r;
    int add_pct;
    logic [ACTION_W-1:0] act;
    r       = $urandom_range(99);
    add_pct = (live_total > 40) ? 10 : 25;
    if (r < 45)                act = ACT_SELECT;
    else if (r < 65)           act = ACT_RELEASE;
    else if (r < 65 + add_pct) act = ACT_ADD;
    else                       act = ACT_REMOVE;
    send_request(act, pick_target(), pick_weight(), RAND_W'($urandom()));
  endtask

  // Empty table, wrap of round robin, release at zero, every policy by hand
  task automatic test_directed();
    idle_mode = IDLE_NONE;
    write_policy(POL_RR);
    send_request(ACT_SELECT,  6'd0,  16'h0000, 16'h0000);
    send_request(ACT_RELEASE, 6'd0,  16'h0000, 16'h0000);
    send_request(ACT_REMOVE,  6'd63, 16'h0000, 16'h0000);
    send_request(ACT_ADD,     6'd63, 16'h8000, 16'hffff);
    send_request(ACT_ADD,     6'd0,  16'h7fff, 16'h0000);
    send_request(ACT_ADD,     6'd0,  16'h0000, 16'h0000);
    repeat (4) send_request(ACT_SELECT, 6'd0, 16'h0000, 16'h0000);
    send_request(ACT_RELEASE, 6'd2,  16'h0000, 16'h0000);
    send_request(ACT_RELEASE, 6'd2,  16'h0000, 16'h0000);
    send_request(ACT_REMOVE,  6'd1,  16'h0000, 16'h0000);
    send_request(ACT_RELEASE, 6'd1,  16'h0000, 16'h0000);
    send_request(ACT_SELECT,  6'd0,  16'h0000, 16'h0000);
    wait_drained();
    write_policy(POL_LEAST);
    repeat (2) send_request(ACT_SELECT, 6'd0, 16'h0000, 16'h0000);
    wait_drained();
    write_policy(POL_RANDOM);
    send_request(ACT_SELECT, 6'd0, 16'h0000, 16'hffff);
    send_request(ACT_SELECT, 6'd0, 16'h0000, 16'h0000);
    wait_drained();
    // no live slot has a positive weight yet
    write_policy(POL_WEIGHT);
    send_request(ACT_SELECT,  6'd0, 16'h0000, 16'h0000);
    send_request(ACT_ADD,     6'd0, 16'h0001, 16'h0000);
    send_request(ACT_SELECT,  6'd0, 16'h0000, 16'h0000);
    send_request(ACT_REMOVE,  6'd0, 16'h0000, 16'h0000);
    send_request(ACT_REMOVE,  6'd2, 16'h0000, 16'h0000);
    send_request(ACT_REMOVE,  6'd1, 16'h0000, 16'h0000);
    send_request(ACT_SELECT,  6'd0, 16'h0000, 16'h0000);
    wait_drained();
  endtask

  // Fill the table past full, select under each policy, then thin it out
  task automatic test_table_fill();
    idle_mode = IDLE_BOTH;
    repeat (SLOTS + 2)
      send_request(ACT_ADD, TARGET_W'($urandom()), pick_weight(), RAND_W'($urandom()));
    for (int p = 0; p < 4; p++) begin
      wait_drained();
      write_policy(p[1:0]);
      repeat (5)
        send_request(ACT_SELECT, TARGET_W'($urandom()), WEIGHT_W'($urandom()),
                     RAND_W'($urandom()));
    end
    repeat (40)
      send_request(ACT_REMOVE, pick_target(), WEIGHT_W'($urandom()), RAND_W'($urandom()));
    wait_drained();
  endtask

  // Hold result ready low while requests keep coming, so the input backs up
  task automatic test_output_hold_off();
    idle_mode = IDLE_NONE;
    write_policy(POL_LEAST);
    hold_start = 1'b1;
    repeat (12) send_random_item();
    wait_drained();
  endtask

  // Random traffic under every policy and every idling pattern
  task automatic test_random_traffic();
    for (int m = 0; m < 4; m++) begin
      for (int p = 0; p < 4; p++) begin
        wait_drained();
        idle_mode = idle_mode_e'(m);
        write_policy(p[1:0]);
        repeat (ITEMS_PER_PHASE) send_random_item();
      end
    end
    wait_drained();
  endtask

  initial begin
    err_cnt     = 0;
    sent_cnt    = 0;
    checked_cnt = 0;
    hold_start  = 1'b0;
    idle_mode   = IDLE_NONE;
    for (int i = 0; i < 4; i++) status_cnt[i] = 0;
    rst                 <= 1'b1;
    req_ch.valid        <= 1'b0;
    req_ch.action       <= ACT_SELECT;
    req_ch.target_slot  <= '0;
    req_ch.new_weight   <= '0;
    req_ch.random_value <= '0;
    cfg_ch.valid        <= 1'b0;
    cfg_ch.data         <= POL_RR;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_table_fill();
    test_output_hold_off();
    test_random_traffic();

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_results.size() != 0)
      report_error($sformatf("%0d expected results never arrived", pending_results.size()));

    $display("Sent %0d requests, checked %0d results: %0d ok, %0d no backend,",
             sent_cnt, checked_cnt, status_cnt[ST_OK], status_cnt[ST_NO_BACKEND]);
    $display("%0d full, %0d not found; all four policies, four idling patterns,",
             status_cnt[ST_FULL], status_cnt[ST_NOT_FOUND]);
    $display("a full table and a %0d-cycle output hold-off", HOLD_CYCLES);
    if (err_cnt == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
